/* src/ccf_pkg.sv */
// ccf_pkg: types, field widths and codes shared by the CAN frame capture FIFO.
// No dependencies; compiled first.
package ccf_pkg;

    localparam int OP_W     = 2;
    localparam int IDENT_W  = 29;
    localparam int ID_W     = 11;
    localparam int CNT_W    = 4;
    localparam int DATA_W   = 64;
    localparam int TIME_W   = 32;
    localparam int DROP_W   = 32;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 1;
    localparam int NUM_BYTES = DATA_W / 8;

    localparam logic [ID_W-1:0]  ID_FIRST_RST  = 11'h7E0;
    localparam logic [ID_W-1:0]  ID_SECOND_RST = 11'h7E8;
    localparam logic [CNT_W-1:0] MAX_BYTES     = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_ID_FIRST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_SECOND = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_FRAME = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_FILTERED   = 3'd0,
        ST_STORED     = 3'd1,
        ST_DROPPED    = 3'd2,
        ST_POPPED     = 3'd3,
        ST_EMPTY      = 3'd4,
        ST_COUNT_READ = 3'd5
    } t_status;

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic               is_extended;
        logic               is_remote;
        logic [IDENT_W-1:0] frame_ident;
        logic [CNT_W-1:0]   length_code;
        logic [DATA_W-1:0]  frame_payload;
        logic [TIME_W-1:0]  arrival_time;
    } t_in_item;

    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic [ID_W-1:0]   ident;
        logic [CNT_W-1:0]  count;
        logic [DATA_W-1:0] payload;
    } t_slot;

    typedef struct packed {
        t_status           status;
        logic [DROP_W-1:0] drop;
        logic              pop;
    } t_meta;

    typedef struct packed {
        t_status           status;
        t_slot             slot;
        logic [DROP_W-1:0] drop;
    } t_result;

endpackage

/* src/ccf_in_if.sv */
// ccf_in_if: input channel carrying frame, pop and clear transactions.
// Depends on ccf_pkg for field widths.
interface ccf_in_if;
    logic                        valid;
    logic                        ready;
    logic [ccf_pkg::OP_W-1:0]    opcode;
    logic                        is_extended;
    logic                        is_remote;
    logic [ccf_pkg::IDENT_W-1:0] frame_ident;
    logic [ccf_pkg::CNT_W-1:0]   length_code;
    logic [ccf_pkg::DATA_W-1:0]  frame_payload;
    logic [ccf_pkg::TIME_W-1:0]  arrival_time;

    modport source (output valid, opcode, is_extended, is_remote, frame_ident,
                    length_code, frame_payload, arrival_time, input ready);
    modport sink   (input valid, opcode, is_extended, is_remote, frame_ident,
                    length_code, frame_payload, arrival_time, output ready);
endinterface

/* src/ccf_out_if.sv */
// ccf_out_if: result channel, one transaction per accepted input transaction.
// Depends on ccf_pkg for field widths.
interface ccf_out_if;
    logic                         valid;
    logic                         ready;
    logic [ccf_pkg::STATUS_W-1:0] status;
    logic [ccf_pkg::TIME_W-1:0]   out_time;
    logic [ccf_pkg::ID_W-1:0]     out_ident;
    logic [ccf_pkg::CNT_W-1:0]    out_byte_count;
    logic [ccf_pkg::DATA_W-1:0]   out_payload;
    logic [ccf_pkg::DROP_W-1:0]   drop_total;

    modport source (output valid, status, out_time, out_ident, out_byte_count,
                    out_payload, drop_total, input ready);
    modport sink   (input valid, status, out_time, out_ident, out_byte_count,
                    out_payload, drop_total, output ready);
endinterface

/* src/ccf_ram.sv */
// ccf_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module ccf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* src/ccf_ctrl.sv */
// ccf_ctrl: acceptance filter, ring pointers, drop counter and ID registers.
// Depends on ccf_pkg; drives the slot RAM ports.
module ccf_ctrl #(
    parameter int RING_DEPTH = 64,
    localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ccf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ccf_pkg::ID_W-1:0]      i_cfg_data,
    input  logic                          i_accept,
    input  ccf_pkg::t_in_item             i_item,
    output logic                          o_ram_we,
    output logic [PW-1:0]                 o_ram_waddr,
    output ccf_pkg::t_slot                o_ram_wdata,
    output logic                          o_ram_re,
    output logic [PW-1:0]                 o_ram_raddr,
    output ccf_pkg::t_meta                o_meta
);
    import ccf_pkg::*;

    localparam logic [PW-1:0] LAST = PW'(RING_DEPTH - 1);

    logic [ID_W-1:0]   r_id_first, r_id_second;
    logic [PW-1:0]     r_wr, r_rd, n_wr, n_rd;
    logic [DROP_W-1:0] r_lost, n_lost;
    logic [PW-1:0]     wr_next, rd_next;
    logic              hit, full, empty;
    logic [CNT_W-1:0]  count;
    logic [DATA_W-1:0] kept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_first  <= ID_FIRST_RST;
            r_id_second <= ID_SECOND_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ID_FIRST:  r_id_first  <= i_cfg_data;
                CFG_ID_SECOND: r_id_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign wr_next = (r_wr == LAST) ? '0 : r_wr + 1'b1;
    assign rd_next = (r_rd == LAST) ? '0 : r_rd + 1'b1;
    assign full    = (wr_next == r_rd);
    assign empty   = (r_rd == r_wr);

    assign hit = !i_item.is_extended && !i_item.is_remote &&
                 ((i_item.frame_ident == {{(IDENT_W-ID_W){1'b0}}, r_id_first}) ||
                  (i_item.frame_ident == {{(IDENT_W-ID_W){1'b0}}, r_id_second}));
    assign count = (i_item.length_code > MAX_BYTES) ? MAX_BYTES : i_item.length_code;

    always_comb begin
        for (int b = 0; b < NUM_BYTES; b++) begin
            kept[8*b +: 8] = (CNT_W'(b) < count) ? i_item.frame_payload[8*b +: 8] : 8'h00;
        end
    end

    always_comb begin
        n_wr          = r_wr;
        n_rd          = r_rd;
        n_lost        = r_lost;
        o_ram_we      = 1'b0;
        o_ram_re      = 1'b0;
        o_meta.status = ST_FILTERED;
        o_meta.pop    = 1'b0;
        if (i_accept) begin
            unique case (t_opcode'(i_item.opcode))
                OP_FRAME: begin
                    if (hit) begin
                        if (full) begin
                            if (r_lost != '1) begin
                                n_lost = r_lost + 1'b1;
                            end
                            o_meta.status = ST_DROPPED;
                        end else begin
                            o_ram_we      = 1'b1;
                            n_wr          = wr_next;
                            o_meta.status = ST_STORED;
                        end
                    end
                end
                OP_POP: begin
                    if (empty) begin
                        o_meta.status = ST_EMPTY;
                    end else begin
                        o_ram_re      = 1'b1;
                        n_rd          = rd_next;
                        o_meta.status = ST_POPPED;
                        o_meta.pop    = 1'b1;
                    end
                end
                OP_CLEAR: begin
                    n_lost        = '0;
                    o_meta.status = ST_COUNT_READ;
                end
                default: ;
            endcase
        end
        o_meta.drop = (o_meta.status == ST_COUNT_READ) ? r_lost : n_lost;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_lost <= '0;
        end else begin
            r_wr   <= n_wr;
            r_rd   <= n_rd;
            r_lost <= n_lost;
        end
    end

    assign o_ram_waddr         = r_wr;
    assign o_ram_raddr         = r_rd;
    assign o_ram_wdata.stamp   = i_item.arrival_time;
    assign o_ram_wdata.ident   = i_item.frame_ident[ID_W-1:0];
    assign o_ram_wdata.count   = count;
    assign o_ram_wdata.payload = kept;
endmodule

/* src/ccf_resp.sv */
// ccf_resp: read-data stage and output register of the result channel.
// Depends on ccf_pkg and ccf_out_if.
module ccf_resp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  ccf_pkg::t_meta  i_meta,
    input  ccf_pkg::t_slot  i_rdata,
    output logic            o_in_ready,
    ccf_out_if.source       o_out
);
    import ccf_pkg::*;

    logic    r_s1_valid, n_s1_valid;
    t_meta   r_s1_meta;
    logic    r_out_valid, n_out_valid;
    t_result r_out;
    logic    s1_move;

    assign s1_move    = r_s1_valid && (!r_out_valid || o_out.ready);
    assign o_in_ready = !r_s1_valid || s1_move;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (i_accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_move) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (s1_move) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_meta <= i_meta;
        end
        if (s1_move) begin
            r_out.status <= r_s1_meta.status;
            r_out.drop   <= r_s1_meta.drop;
            r_out.slot   <= r_s1_meta.pop ? i_rdata : '0;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out.status;
    assign o_out.out_time       = r_out.slot.stamp;
    assign o_out.out_ident      = r_out.slot.ident;
    assign o_out.out_byte_count = r_out.slot.count;
    assign o_out.out_payload    = r_out.slot.payload;
    assign o_out.drop_total     = r_out.drop;
endmodule

/* src/can_frame_capture_fifo_top.sv */
// can_frame_capture_fifo_top: CAN receive filter feeding a frame capture ring.
// Depends on ccf_pkg, ccf_in_if, ccf_out_if, ccf_ram, ccf_ctrl, ccf_resp.
//
// Takes one transaction per clock unless the result stage and output register are full
// and output stalls. Each gives exactly one result via the result stage (slot RAM read
// data for pops) and the output register; these decouple the channels, so input stays
// ready while one result waits. Only standard-ID data frames matching one of two ID
// registers are kept; the ring holds RING_DEPTH-1 entries, and matching frames arriving
// when full bump a saturating drop count. Slots need no clearing after reset.
module can_frame_capture_fifo_top #(
    parameter int RING_DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ccf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ccf_pkg::ID_W-1:0]      i_cfg_data,
    ccf_in_if.sink                        i_in,
    ccf_out_if.source                     o_out
);
    import ccf_pkg::*;

    localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    t_in_item        item;
    t_meta           meta;
    t_slot           wdata, rdata;
    logic            accept, in_ready;
    logic            ram_we, ram_re;
    logic [PW-1:0]   waddr, raddr;

    assign item.opcode        = i_in.opcode;
    assign item.is_extended   = i_in.is_extended;
    assign item.is_remote     = i_in.is_remote;
    assign item.frame_ident   = i_in.frame_ident;
    assign item.length_code   = i_in.length_code;
    assign item.frame_payload = i_in.frame_payload;
    assign item.arrival_time  = i_in.arrival_time;

    assign i_in.ready = in_ready;
    assign accept     = i_in.valid && in_ready;

    ccf_ctrl #(.RING_DEPTH(RING_DEPTH)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_item      (item),
        .o_ram_we    (ram_we),
        .o_ram_waddr (waddr),
        .o_ram_wdata (wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (raddr),
        .o_meta      (meta)
    );

    ccf_ram #(.WIDTH($bits(t_slot)), .DEPTH(RING_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (ram_re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    ccf_resp u_resp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_meta     (meta),
        .i_rdata    (rdata),
        .o_in_ready (in_ready),
        .o_out      (o_out)
    );
endmodule

/* src/ccf_check.sv */
// ccf_check: port-level assertions for the CAN frame capture FIFO, bound to the top.
// Depends on ccf_pkg and can_frame_capture_fifo_top.
module ccf_check (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [ccf_pkg::STATUS_W-1:0] i_status,
    input logic [ccf_pkg::TIME_W-1:0]   i_out_time,
    input logic [ccf_pkg::ID_W-1:0]     i_out_ident,
    input logic [ccf_pkg::CNT_W-1:0]    i_out_byte_count,
    input logic [ccf_pkg::DATA_W-1:0]   i_out_payload,
    input logic [ccf_pkg::DROP_W-1:0]   i_drop_total
);
    import ccf_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid straight after reset");

    a_no_pop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_POPPED |->
            i_out_time == '0 && i_out_ident == '0 && i_out_byte_count == '0 &&
            i_out_payload == '0)
        else $error("entry fields set on a non-pop result");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_POPPED |-> i_out_byte_count <= MAX_BYTES)
        else $error("popped byte count above eight");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_status) && $stable(i_drop_total) &&
            $stable(i_out_payload))
        else $error("stalled result changed");
endmodule

bind can_frame_capture_fifo_top ccf_check u_ccf_check (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_status         (o_out.status),
    .i_out_time       (o_out.out_time),
    .i_out_ident      (o_out.out_ident),
    .i_out_byte_count (o_out.out_byte_count),
    .i_out_payload    (o_out.out_payload),
    .i_drop_total     (o_out.drop_total)
);
